[hdl/cas_pkg.sv]
package cas_pkg;

    localparam int MAX_ROWS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int VALUE_W   = 32;
    localparam int COLUMN_W  = 7;
    localparam int ROW_W     = 7;
    localparam int RANK_W    = 6;

    localparam int IN_TDATA_W  = ((VALUE_W + COLUMN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ROW_W + RANK_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_KEY,
        ST_FIRST,
        ST_CMP,
        ST_ERD,
        ST_EMIT
    } state_t;

endpackage

[hdl/column_argsort_with_ranks.sv]
// Channel  Dir  Handshake        Payload
// s_*      in   tvalid/tready    tdata: value[31:0], column_index[38:32]; tlast: last_row
// m_*      out  tvalid/tready    tdata: sorted_row[6:0], row_rank[12:7]; tlast: last_out
// cfg_*    in   cfg_we           cfg_wdata: one_sided
//
// Rows load one per cycle. After the last row, the rows are ranked one after another
// through one shared comparator, one compare per cycle against the value RAM's read port.
// Each result is then read from a registered RAM, then output.
// No input is taken from the last row until the final result transaction.
// Reset clears control state only; the RAMs hold no reset value.
module column_argsort_with_ranks #(
    parameter int MAX_ROWS   = cas_pkg::MAX_ROWS_DEF,
    parameter int VALUE_BITS = cas_pkg::VALUE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cas_pkg::IN_TDATA_W-1:0]   s_tdata,   // value, column_index
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cas_pkg::OUT_TDATA_W-1:0]  m_tdata,   // sorted_row, row_rank
    output logic                             m_tlast
);
    import cas_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam logic [VALUE_BITS-1:0] SIGN_FLIP = {1'b1, {(VALUE_BITS-1){1'b0}}};

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          n_reg, n_next;
    logic [RW-1:0]          i_reg, i_next;
    logic [RW-1:0]          j_reg, j_next;
    logic [RW-1:0]          k_reg, k_next;
    logic [RW-1:0]          cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0]  key_reg, key_next;
    logic [COLUMN_W-1:0]    own_column_reg, own_column_next;
    logic                   one_sided_reg;

    logic [VALUE_BITS-1:0]  val_mem [MAX_ROWS];
    logic [RW-1:0]          order_mem [MAX_ROWS];
    logic [RW-1:0]          rank_mem [MAX_ROWS];
    logic [VALUE_BITS-1:0]  val_rd_reg;
    logic [RW-1:0]          order_rd_reg;
    logic [RW-1:0]          rank_rd_reg;

    logic                   val_we;
    logic [RW-1:0]          val_raddr;
    logic                   sort_we;
    logic [RW-1:0]          cnt_sum;
    logic                   beats;
    logic                   j_last;

    logic signed [VALUE_W-1:0] in_value;
    logic [VALUE_BITS-1:0]     in_key;
    logic [ROW_W-1:0]          row_raw;
    logic [ROW_W-1:0]          row_adj;

    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_key   = VALUE_BITS'(in_value) ^ SIGN_FLIP;

    assign beats   = (val_rd_reg > key_reg) || ((val_rd_reg == key_reg) && (j_reg < i_reg));
    assign cnt_sum = cnt_reg + RW'(beats);
    assign j_last  = (CW'(j_reg) == n_reg - CW'(1));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        key_next        = key_reg;
        own_column_next = own_column_reg;
        val_we          = 1'b0;
        sort_we         = 1'b0;
        val_raddr       = i_reg;
        s_tready        = 1'b0;
        m_tvalid        = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (count_reg < CW'(MAX_ROWS))
                    begin
                        val_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (s_tlast)
                    begin
                        own_column_next = s_tdata[VALUE_W +: COLUMN_W];
                        n_next          = count_next;
                        count_next      = '0;
                        i_next          = '0;
                        state_next      = ST_KEY;
                    end
                end
            end
            ST_KEY:
            begin
                val_raddr  = i_reg;
                state_next = ST_FIRST;
            end
            ST_FIRST:
            begin
                key_next   = val_rd_reg;
                val_raddr  = '0;
                j_next     = '0;
                cnt_next   = '0;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                val_raddr = j_reg + RW'(1);
                cnt_next  = cnt_sum;
                if (j_last)
                begin
                    sort_we = 1'b1;
                    if (CW'(i_reg) == n_reg - CW'(1))
                    begin
                        k_next     = '0;
                        state_next = ST_ERD;
                    end
                    else
                    begin
                        i_next     = i_reg + RW'(1);
                        state_next = ST_KEY;
                    end
                end
                else
                begin
                    j_next = j_reg + RW'(1);
                end
            end
            ST_ERD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (m_tlast)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + RW'(1);
                        state_next = ST_ERD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            n_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            cnt_reg        <= '0;
            own_column_reg <= '0;
            one_sided_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            n_reg          <= n_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            cnt_reg        <= cnt_next;
            own_column_reg <= own_column_next;
            if (cfg_we)
            begin
                one_sided_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[count_reg[RW-1:0]] <= in_key;
        end
        val_rd_reg <= val_mem[val_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sort_we)
        begin
            order_mem[cnt_sum] <= i_reg;
            rank_mem[i_reg]    <= cnt_sum;
        end
        order_rd_reg <= order_mem[k_reg];
        rank_rd_reg  <= rank_mem[k_reg];
    end

    // one-sided: skip the column's own agent
    assign row_raw = ROW_W'(order_rd_reg);
    assign row_adj = (one_sided_reg && (row_raw >= own_column_reg)) ? row_raw + ROW_W'(1)
                                                                    : row_raw;

    assign m_tdata = OUT_TDATA_W'({RANK_W'(rank_rd_reg), row_adj});
    assign m_tlast = (CW'(k_reg) == n_reg - CW'(1));

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ROWS))
        else $error("row count overflow");

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (CW'(rank_rd_reg) < n_reg))
        else $error("rank outside column");

    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && (count_reg == '0)))
        else $error("no return to loading after last result");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (!s_tready && (n_reg != '0)))
        else $error("column not closed on last row");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import cas_pkg::*;

    localparam int ROWS        = MAX_ROWS_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int SEG_ITEMS   = 44;

    typedef enum logic {
        ROW_ITEM,
        ROW_MODE
    } row_kind_t;

    typedef struct packed {
        logic [6:0] row;
        logic [5:0] rank;
        logic       last;
    } result_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        mode;
        logic [31:0] value;
        logic [6:0]  col;
        logic        last;
        logic        typed;
        logic [6:0]  exp_row;
        logic [5:0]  exp_rank;
    } dir_row_t;

    localparam dir_row_t DIRECTED [21] = '{
        '{ROW_ITEM, 1'b0, 32'h7FFF_FFFF, 7'd0,  1'b1, 1'b1, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'h8000_0000, 7'd64, 1'b1, 1'b1, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'h0000_0000, 7'd5,  1'b0, 1'b0, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'hFFFF_FFFF, 7'd0,  1'b0, 1'b0, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'h7FFF_FFFF, 7'd0,  1'b0, 1'b0, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'h8000_0000, 7'd3,  1'b1, 1'b0, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'h0000_0005, 7'd0,  1'b0, 1'b0, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'h0000_0005, 7'd0,  1'b0, 1'b0, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'h0000_0005, 7'd1,  1'b1, 1'b0, 7'd0, 6'd0},
        '{ROW_MODE, 1'b1, 32'h0000_0000, 7'd0,  1'b0, 1'b0, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'h0000_0000, 7'd0,  1'b1, 1'b1, 7'd1, 6'd0},
        '{ROW_ITEM, 1'b0, 32'h0000_0000, 7'd1,  1'b1, 1'b1, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'h0000_0010, 7'd0,  1'b0, 1'b0, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'hFFFF_FFF0, 7'd0,  1'b0, 1'b0, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'h0000_0010, 7'd0,  1'b0, 1'b0, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'h7FFF_FFFF, 7'd0,  1'b0, 1'b0, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'h8000_0000, 7'd2,  1'b1, 1'b0, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'h0000_0001, 7'd0,  1'b0, 1'b0, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'h0000_0001, 7'd0,  1'b0, 1'b0, 7'd0, 6'd0},
        '{ROW_ITEM, 1'b0, 32'h0000_0001, 7'd64, 1'b1, 1'b0, 7'd0, 6'd0},
        '{ROW_MODE, 1'b0, 32'h0000_0000, 7'd0,  1'b0, 1'b0, 7'd0, 6'd0}
    };

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic                   cfg_wdata = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;

    // column predictor state
    logic signed [31:0] col_vals [ROWS];
    int                 row_cnt     = 0;
    logic [6:0]         own_col     = '0;
    bit                 one_sided_q = 1'b0;
    result_t            pending_order [$];

    column_argsort_with_ranks dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic void rank_column(input logic signed [31:0] value, input logic [6:0] col,
                                        input bit last);
        int      ord [ROWS];
        int      rank_of [ROWS];
        int      n;
        int      j;
        int      row;
        result_t r;
        if (row_cnt < ROWS)
        begin
            col_vals[row_cnt] = value;
            row_cnt++;
        end
        if (!last)
            return;
        own_col = col;
        n = row_cnt;
        // stable descending insertion sort
        for (int i = 0; i < n; i++)
        begin
            j = i;
            while (j > 0 && col_vals[ord[j - 1]] < col_vals[i])
            begin
                ord[j] = ord[j - 1];
                j--;
            end
            ord[j] = i;
        end
        for (int i = 0; i < n; i++)
            rank_of[ord[i]] = i;
        for (int k = 0; k < n; k++)
        begin
            row = ord[k];
            if (one_sided_q && row >= int'(own_col))
                row++;
            r.row  = 7'(row);
            r.rank = 6'(rank_of[k]);
            r.last = (k == n - 1);
            pending_order.push_back(r);
        end
        row_cnt = 0;
    endfunction

    function automatic void report(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected row %0d rank %0d last %0d, got row %0d rank %0d last %0d",
                     what, want.row, want.rank, want.last, got.row, got.rank, got.last);
    endfunction

    function automatic logic [31:0] pick_value(input int mode);
        logic [31:0] v;
        v = $urandom;
        case (mode)
            1: v = 32'($urandom_range(0, 6)) - 32'd3;
            2:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    default: v = $urandom;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic push_item(input logic [31:0] value, input logic [6:0] col, input bit last,
                             input bit typed, input result_t typed_res);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, col, value};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        rank_column(value, col, last);
        if (typed && last)
        begin
            void'(pending_order.pop_back());
            pending_order.push_back(typed_res);
        end
    endtask

    task automatic send_column(input int rows);
        int         mode;
        logic [6:0] col;
        mode = $urandom_range(0, 2);
        col  = $urandom_range(0, 1) ? 7'($urandom_range(0, 64)) : 7'($urandom_range(0, rows));
        if (col > 7'd64)
            col = 7'd64;
        for (int i = 0; i < rows; i++)
            push_item(pick_value(mode), (i == rows - 1) ? col : 7'($urandom_range(0, 64)),
                      i == rows - 1, 1'b0, '0);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_order.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mode(input bit v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        one_sided_q = v;
    endtask

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        got = {m_tdata[6:0], m_tdata[12:7], m_tlast};
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_order.size() == 0)
                report("unexpected result", '0, got);
            else
            begin
                want = pending_order.pop_front();
                if (got != want)
                    report("mismatch", want, got);
            end
        end
        m_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        int seg;
        int sent;
        int size;
        int r;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(1'b0);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_MODE)
            begin
                settle();
                write_mode(DIRECTED[i].mode);
            end
            else
                push_item(DIRECTED[i].value, DIRECTED[i].col, DIRECTED[i].last,
                          DIRECTED[i].typed,
                          {DIRECTED[i].exp_row, DIRECTED[i].exp_rank, 1'b1});
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int m = 0; m < 2; m++)
            begin
                seg = ph * 2 + m;
                settle();
                write_mode(m == 0);
                case (ph)
                    0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                    1: begin snd_idle_pct = 56; rcv_stall_pct = 0;  end
                    2: begin snd_idle_pct = 0;  rcv_stall_pct = 56; end
                    default: begin snd_idle_pct = 18; rcv_stall_pct = 18; end
                endcase
                sent = 0;
                // an overflow column forced in segment 2, a full column in segment 5
                if (seg == 2)
                begin
                    send_column(66);
                    sent += 66;
                end
                else if (seg == 5)
                begin
                    send_column(64);
                    sent += 64;
                end
                while (sent < SEG_ITEMS)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 2)
                        size = $urandom_range(60, 70);
                    else if (r < 20)
                        size = $urandom_range(9, 24);
                    else
                        size = $urandom_range(1, 8);
                    send_column(size);
                    sent += size;
                end
            end
        end

        settle();
        repeat (32) @(posedge clk);
        if (mismatches == 0 && pending_order.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[column_argsort_with_ranks.f]
hdl/cas_pkg.sv
hdl/column_argsort_with_ranks.sv
tb/tb_top.sv
